@@ src/sscd_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial servo command decoder package
// Shared types, character codes, register indexes and the angle scaling
// function used by the decoder core and the top level.
// ----------------------------------------------------------------------------
package sscd_pkg;

  // Event code reported with every result item.
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_LED_OFF    = 3'd1,
    EV_LED_ON     = 3'd2,
    EV_LED_TOGGLE = 3'd3,
    EV_COUNT      = 3'd4,
    EV_SERVO      = 3'd5,
    EV_ERROR      = 3'd6
  } sscd_event_t;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFFSET = 1'b1;

  // Register reset values.
  localparam logic [7:0] ANGLE_LIMIT_RST  = 8'd180;
  localparam logic [9:0] PULSE_OFFSET_RST = 10'd44;

  // Character codes.
  localparam logic [7:0] CH_S     = 8'h73; // 's'
  localparam logic [7:0] CH_DOT   = 8'h2E; // '.'
  localparam logic [7:0] CH_A     = 8'h61; // 'a'
  localparam logic [7:0] CH_B     = 8'h62; // 'b'
  localparam logic [7:0] CH_C     = 8'h63; // 'c'
  localparam logic [7:0] CH_D     = 8'h64; // 'd'
  localparam logic [7:0] CH_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CH_NINE  = 8'h39; // '9'

  // Reciprocal of nine scaled by 2^16, rounded up. Exact for dividends
  // below 2^15, far above the largest scaled angle of 1275.
  localparam logic [12:0] RECIP_NINE = 13'd7282;

  // One result item before it is packed onto the stream.
  typedef struct packed {
    logic [7:0]  echo_byte;
    logic        line_end;
    sscd_event_t event_res;
    logic        led_lit;
    logic [7:0]  servo_angle;
    logic [10:0] pulse_compare;
    logic [7:0]  byte_count;
  } sscd_result_t;

  // 5*angle/9 with integer truncation, by a constant multiply and shift.
  function automatic logic [7:0] scale_angle(input logic [7:0] angle);
    logic [10:0] times5;
    logic [23:0] prod;
    begin
      times5 = {1'b0, angle, 2'b00} + {3'b000, angle};
      prod   = {13'd0, times5} * {11'd0, RECIP_NINE};
      return prod[23:16];
    end
  endfunction

endpackage

@@ src/sscd_core.sv @@
// ----------------------------------------------------------------------------
// Serial servo command decoder core
// Holds the command state and works out the result for one received byte.
// The state advances only when an item is accepted.
// ----------------------------------------------------------------------------
module sscd_core
  import sscd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         fire,
  input  logic [7:0]   rx_byte,
  input  logic [7:0]   angle_limit,
  input  logic [9:0]   pulse_offset,
  output sscd_result_t res
);

  logic        number_mode_r, number_mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic        led_r, led_nxt;
  logic [7:0]  angle_r, angle_nxt;
  logic [7:0]  count_r, count_nxt;

  logic        is_digit;
  logic [3:0]  digit;
  logic [15:0] acc_times10;
  logic [7:0]  clamped;
  logic        line_end;
  sscd_event_t ev;

  assign is_digit    = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
  assign digit       = rx_byte[3:0];
  assign acc_times10 = {acc_r[12:0], 3'b000} + {acc_r[14:0], 1'b0};
  assign count_nxt   = count_r + 8'd1;

  // The finished number is signed; negative values clamp to zero.
  always_comb begin
    if (acc_r[15]) begin
      clamped = 8'd0;
    end else if (acc_r[14:0] > {7'd0, angle_limit}) begin
      clamped = angle_limit;
    end else begin
      clamped = acc_r[7:0];
    end
  end

  always_comb begin
    number_mode_nxt = number_mode_r;
    acc_nxt         = acc_r;
    led_nxt         = led_r;
    angle_nxt       = angle_r;
    line_end        = 1'b0;
    ev              = EV_NONE;
    if (!number_mode_r) begin
      if (rx_byte == CH_S) begin
        number_mode_nxt = 1'b1;
      end else begin
        line_end = 1'b1;
        unique case (rx_byte)
          CH_A: begin
            led_nxt = 1'b0;
            ev      = EV_LED_OFF;
          end
          CH_B: begin
            led_nxt = 1'b1;
            ev      = EV_LED_ON;
          end
          CH_C: begin
            led_nxt = !led_r;
            ev      = EV_LED_TOGGLE;
          end
          CH_D: begin
            ev = EV_COUNT;
          end
          default: begin
            ev = EV_ERROR;
          end
        endcase
      end
    end else begin
      if (is_digit) begin
        acc_nxt = acc_times10 + {12'd0, digit};
      end else if (rx_byte == CH_DOT) begin
        angle_nxt       = clamped;
        acc_nxt         = 16'd0;
        number_mode_nxt = 1'b0;
        line_end        = 1'b1;
        ev              = EV_SERVO;
      end
    end
  end

  always_comb begin
    res.echo_byte     = rx_byte;
    res.line_end      = line_end;
    res.event_res     = ev;
    res.led_lit       = led_nxt;
    res.servo_angle   = angle_nxt;
    res.pulse_compare = {3'd0, scale_angle(angle_nxt)} + {1'b0, pulse_offset};
    res.byte_count    = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_mode_r <= 1'b0;
      acc_r         <= 16'd0;
      led_r         <= 1'b0;
      angle_r       <= 8'd0;
      count_r       <= 8'd0;
    end else if (fire) begin
      number_mode_r <= number_mode_nxt;
      acc_r         <= acc_nxt;
      led_r         <= led_nxt;
      angle_r       <= angle_nxt;
      count_r       <= count_nxt;
    end
  end

endmodule

@@ src/serial_servo_command_decoder.sv @@
// ----------------------------------------------------------------------------
// Serial servo command decoder
// Decodes received serial bytes into LED, count report and servo angle
// commands, and reports one result item per byte.
// ----------------------------------------------------------------------------
// Each accepted byte's result is registered in the output register.
// Throughput: one byte per cycle while out_tready is high or no result is held;
// the output register accepts a new item in the same cycle its held result is taken.
// Reset (synchronous, rst_n low): command state idle, count and angle zero,
// LED off, angle_limit 180, pulse_offset 44, no result pending.
module serial_servo_command_decoder
  import sscd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // Received byte channel.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  // Result channel.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [7:0] echo_byte, [8] led_lit, [16:9] servo_angle,
  // [27:17] pulse_compare, [35:28] byte_count, [39:36] zero
  output logic [39:0]          out_tdata,
  output logic                 out_tlast,  // line_end
  output logic [2:0]           out_tuser,  // event_res
  // Configuration write port.
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_addr,
  input  logic [9:0]           cfg_wdata
);

  logic [7:0]   angle_limit_r;
  logic [9:0]   pulse_offset_r;
  logic         out_valid_r;
  sscd_result_t res_r;
  sscd_result_t res;
  logic         fire;

  assign in_tready = !out_valid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  sscd_core u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .rx_byte      (in_tdata),
    .angle_limit  (angle_limit_r),
    .pulse_offset (pulse_offset_r),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_limit_r  <= ANGLE_LIMIT_RST;
      pulse_offset_r <= PULSE_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ANGLE_LIMIT:  angle_limit_r  <= cfg_wdata[7:0];
        REG_PULSE_OFFSET: pulse_offset_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.byte_count, res_r.pulse_compare, res_r.servo_angle,
                       res_r.led_lit, res_r.echo_byte};
  assign out_tlast  = res_r.line_end;
  assign out_tuser  = res_r.event_res;

`ifndef ASSERT_OFF
  a_reset_clears_valid: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("accepted item produced no result");

  a_servo_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.event_res == EV_SERVO) |-> res_r.line_end)
    else $error("servo set without line end");

  a_line_end_has_event: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && res_r.line_end) |-> (res_r.event_res != EV_NONE))
    else $error("line end without an event");
`endif

endmodule
